// ===== rtl/dmab_pkg.sv =====
// ----------------------------------------------------------------------------
// dmab_pkg
// Shared types and constants for the dual moving average beacon direction
// block: field widths, opcodes, direction codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dmab_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned DIR_W    = 2;

  // default window length and reset threshold
  localparam int unsigned WINDOW_DEFAULT  = 5;
  localparam int unsigned THRESHOLD_RESET = 512;

  // request opcodes
  localparam logic OP_SLIDE = 1'b0;
  localparam logic OP_PRIME = 1'b1;

  // reported beacon direction
  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_t;

  // control from the front end to each window
  typedef struct packed {
    logic load;   // request accepted this cycle
    logic prime;  // fill the whole window with the sample
  } win_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/dmab_window.sv =====
// ----------------------------------------------------------------------------
// dmab_window
// Boxcar window of the last WINDOW samples of one sensor with its running
// sum. A slide drops the oldest sample, a prime fills every tap.
// ----------------------------------------------------------------------------
`default_nettype none

module dmab_window #(
  parameter int unsigned WINDOW = dmab_pkg::WINDOW_DEFAULT,
  parameter int unsigned SUM_W  = 13
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dmab_pkg::win_ctrl_t           ctrl,
  input  wire logic [dmab_pkg::SAMPLE_W-1:0] sample,
  output logic      [SUM_W-1:0]              total
);

  logic [dmab_pkg::SAMPLE_W-1:0] taps [WINDOW];
  logic [SUM_W-1:0]              total_next;

  // running sum update
  always_comb begin
    if (ctrl.prime) begin
      total_next = SUM_W'(sample * WINDOW);
    end else begin
      total_next = total - SUM_W'(taps[WINDOW-1]) + SUM_W'(sample);
    end
  end

  // shift line, oldest sample at the far end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(WINDOW); i++) begin
        taps[i] <= '0;
      end
      total <= '0;
    end else if (ctrl.load) begin
      for (int i = 0; i < int'(WINDOW); i++) begin
        if (ctrl.prime || i == 0) begin
          taps[i] <= sample;
        end else begin
          taps[i] <= taps[i-1];
        end
      end
      total <= total_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dmab_decide.sv =====
// ----------------------------------------------------------------------------
// dmab_decide
// Threshold compare of both running sums and the result register. Holds the
// scaled threshold written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmab_decide #(
  parameter int unsigned WINDOW = dmab_pkg::WINDOW_DEFAULT,
  parameter int unsigned SUM_W  = 13
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_load,
  input  wire logic [dmab_pkg::SAMPLE_W-1:0] cfg_threshold,
  input  wire logic                          load,
  input  wire logic [SUM_W-1:0]              left_total,
  input  wire logic [SUM_W-1:0]              right_total,
  output dmab_pkg::dir_t                     direction,
  output logic                               arrived
);

  logic [SUM_W-1:0] limit;
  logic             left_hit;
  logic             right_hit;
  dmab_pkg::dir_t   direction_next;

  // threshold scaled by the window length
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= SUM_W'(dmab_pkg::THRESHOLD_RESET * WINDOW);
    end else if (cfg_load) begin
      limit <= SUM_W'(cfg_threshold * WINDOW);
    end
  end

  // per side detection and direction pick, tie goes right
  always_comb begin
    left_hit  = left_total > limit;
    right_hit = right_total > limit;
    priority if (left_hit && right_hit) begin
      direction_next = (left_total > right_total) ? dmab_pkg::DIR_LEFT
                                                  : dmab_pkg::DIR_RIGHT;
    end else if (left_hit) begin
      direction_next = dmab_pkg::DIR_LEFT;
    end else if (right_hit) begin
      direction_next = dmab_pkg::DIR_RIGHT;
    end else begin
      direction_next = dmab_pkg::DIR_NONE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      direction <= direction_next;
      arrived   <= left_hit || right_hit;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dual_moving_average_beacon_direction_core.sv =====
// ----------------------------------------------------------------------------
// dual_moving_average_beacon_direction_core
// Dual boxcar moving average over left and right sensor samples with a
// threshold detector that reports the beacon direction.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_ready) carries one sample pair per request;
//   opcode slides the window by one pair or primes the whole window.
//   output channel (out_valid/out_ready) returns direction and arrived,
//   exactly one result per request, in order.
//   config channel (cfg_valid/cfg_ready) writes the threshold; write it only
//   while no request is in flight.
// Timing:
//   the window and sums update at accept; the compare then lands in the
//   result register once the output stage is free.
//   one request per cycle is sustained while out_ready stays high.
// Reset:
//   rst clears both windows and sums, the pipeline valids, and sets the
//   threshold to 512. Ready is low during reset.
// Stall:
//   when out_ready is low, the result holds, the middle stage fills, and then
//   in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_moving_average_beacon_direction_core #(
  parameter int unsigned WINDOW = dmab_pkg::WINDOW_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          opcode,
  input  wire logic [dmab_pkg::SAMPLE_W-1:0] left_sample,
  input  wire logic [dmab_pkg::SAMPLE_W-1:0] right_sample,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [dmab_pkg::DIR_W-1:0]    direction,
  output logic                               arrived,
  // config channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dmab_pkg::SAMPLE_W-1:0] threshold
);

  localparam int unsigned SUM_W =
    $clog2(WINDOW * ((1 << dmab_pkg::SAMPLE_W) - 1) + 1);

  logic                mid_valid;
  logic                out_free;
  logic                mid_advance;
  dmab_pkg::win_ctrl_t win_ctrl;
  logic [SUM_W-1:0]    left_total;
  logic [SUM_W-1:0]    right_total;
  dmab_pkg::dir_t      dir_q;

  // handshake and stage enables
  always_comb begin
    out_free       = !out_valid || out_ready;
    mid_advance    = mid_valid && out_free;
    in_ready       = !rst && (!mid_valid || out_free);
    cfg_ready      = !rst;
    win_ctrl.load  = in_valid && in_ready;
    win_ctrl.prime = opcode == dmab_pkg::OP_PRIME;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (win_ctrl.load) begin
        mid_valid <= 1'b1;
      end else if (mid_advance) begin
        mid_valid <= 1'b0;
      end
      if (mid_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  dmab_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_left (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (win_ctrl),
    .sample (left_sample),
    .total  (left_total)
  );

  dmab_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_right (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (win_ctrl),
    .sample (right_sample),
    .total  (right_total)
  );

  dmab_decide #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_decide (
    .clk           (clk),
    .rst           (rst),
    .cfg_load      (cfg_valid && cfg_ready),
    .cfg_threshold (threshold),
    .load          (mid_advance),
    .left_total    (left_total),
    .right_total   (right_total),
    .direction     (dir_q),
    .arrived       (arrived)
  );

  assign direction = dir_q;

endmodule

`default_nettype wire

// ===== rtl/dmab_checker.sv =====
// ----------------------------------------------------------------------------
// dmab_checker
// Port-level checks for the beacon direction core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dmab_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [dmab_pkg::DIR_W-1:0]    direction,
  input wire logic                          arrived
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(direction) && $stable(arrived))
    else $error("result changed while stalled");

  // arrived agrees with the reported direction
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (arrived == (direction != dmab_pkg::DIR_NONE)))
    else $error("arrived does not match direction");

  // direction code is never the unused value
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (direction == dmab_pkg::DIR_NONE || direction == dmab_pkg::DIR_LEFT ||
                   direction == dmab_pkg::DIR_RIGHT))
    else $error("unused direction code");

  // a fresh result traces back to an accepted request, through the middle and output stage registers
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && !rst, 2))
    else $error("result without a request");

  // reset empties the output
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dual_moving_average_beacon_direction_core dmab_checker u_dmab_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .direction (direction),
  .arrived   (arrived)
);

`default_nettype wire

// ===== test/tb_dual_moving_average_beacon_direction_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_moving_average_beacon_direction_core
// Self-checking bench for the dual moving average beacon detector. A short
// table of directed requests (window wrap, prime, ties, threshold boundaries
// and extremes) is followed by random phases, each under its own threshold.
// Every accepted request is run through a local window model and the result
// stream is compared in order, field by field.
// ----------------------------------------------------------------------------

module tb_dual_moving_average_beacon_direction_core;

  localparam int unsigned WIN        = dmab_pkg::WINDOW_DEFAULT;
  localparam int          SAMPLE_MAX = (1 << dmab_pkg::SAMPLE_W) - 1;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_REQS = 180;

  typedef logic [dmab_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    dmab_pkg::dir_t dir;
    logic           arrived;
  } beacon_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_REQ,
    ROW_REQ_KNOWN
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    sample_t   thr;
    logic      op;
    sample_t   left_val;
    sample_t   right_val;
    beacon_t   want;
  } row_t;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_ready;
  logic    opcode;
  sample_t left_sample;
  sample_t right_sample;
  logic    out_valid;
  logic    out_ready;
  logic [dmab_pkg::DIR_W-1:0] direction;
  logic    arrived;
  logic    cfg_valid;
  logic    cfg_ready;
  sample_t threshold;

  // typed expectation traveling with the request payload
  logic    req_known;
  beacon_t req_want;

  // window model
  sample_t     left_ring [WIN];
  sample_t     right_ring [WIN];
  int unsigned left_sum;
  int unsigned right_sum;
  int unsigned ring_pos;
  sample_t     thr_model;

  beacon_t     pending_beacons [$];
  row_t        directed_rows [$];
  int unsigned errors;
  bit          quiet;

  dual_moving_average_beacon_direction_core #(
    .WINDOW(WIN)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .left_sample (left_sample),
    .right_sample(right_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .direction   (direction),
    .arrived     (arrived),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .threshold   (threshold)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (errors < 100) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    errors++;
  endtask

  // advance the window by one request and work out the beacon it reports
  function automatic beacon_t step_beacon(logic op, sample_t l, sample_t r);
    int unsigned limit;
    logic        left_hit;
    logic        right_hit;
    beacon_t     b;
    if (op == dmab_pkg::OP_PRIME) begin
      for (int i = 0; i < WIN; i++) begin
        left_ring[i]  = l;
        right_ring[i] = r;
      end
      left_sum  = l * WIN;
      right_sum = r * WIN;
      ring_pos  = 0;
    end else begin
      left_sum  = left_sum - left_ring[ring_pos] + l;
      right_sum = right_sum - right_ring[ring_pos] + r;
      left_ring[ring_pos]  = l;
      right_ring[ring_pos] = r;
      ring_pos = (ring_pos == WIN - 1) ? 0 : ring_pos + 1;
    end
    // exact average compare: sum > threshold * window
    limit     = thr_model * WIN;
    left_hit  = left_sum > limit;
    right_hit = right_sum > limit;
    if (left_hit && right_hit) begin
      b.dir = (left_sum > right_sum) ? dmab_pkg::DIR_LEFT : dmab_pkg::DIR_RIGHT;
    end else if (left_hit) begin
      b.dir = dmab_pkg::DIR_LEFT;
    end else if (right_hit) begin
      b.dir = dmab_pkg::DIR_RIGHT;
    end else begin
      b.dir = dmab_pkg::DIR_NONE;
    end
    b.arrived = left_hit || right_hit;
    return b;
  endfunction

  // sample values: spread, rails, or close to the current threshold
  function automatic sample_t pick_sample(int center);
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, SAMPLE_MAX);
      1: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      default: v = center + int'($urandom_range(0, 48)) - 24;
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return sample_t'(v);
  endfunction

  function automatic void add_cfg(sample_t value);
    row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.thr  = value;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_req(logic op, sample_t l, sample_t r);
    row_t row;
    row           = '0;
    row.kind      = ROW_REQ;
    row.op        = op;
    row.left_val  = l;
    row.right_val = r;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(logic op, sample_t l, sample_t r,
                                    dmab_pkg::dir_t d, logic a);
    row_t row;
    row              = '0;
    row.kind         = ROW_REQ_KNOWN;
    row.op           = op;
    row.left_val     = l;
    row.right_val    = r;
    row.want.dir     = d;
    row.want.arrived = a;
    directed_rows.push_back(row);
  endfunction

  // one request: optional idle burst, then hold until accepted
  task automatic send_request(logic op, sample_t l, sample_t r, logic known, beacon_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    opcode       <= op;
    left_sample  <= l;
    right_sample <= r;
    req_known    <= known;
    req_want     <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // threshold write once the block has drained
  task automatic write_threshold(sample_t value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beacons.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_valid <= 1'b1;
    threshold <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall bursts, none in the final phase
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      repeat ($urandom_range(1, 12)) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // model update on accepted requests, compare on accepted results
  always @(posedge clk) begin
    beacon_t want;
    if (rst) begin
      for (int i = 0; i < WIN; i++) begin
        left_ring[i]  = '0;
        right_ring[i] = '0;
      end
      left_sum  = 0;
      right_sum = 0;
      ring_pos  = 0;
      thr_model = sample_t'(dmab_pkg::THRESHOLD_RESET);
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_model = threshold;
      end
      if (in_valid && in_ready) begin
        want = step_beacon(opcode, left_sample, right_sample);
        if (req_known) want = req_want;
        pending_beacons.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_beacons.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: direction %0d arrived %0b",
                                    direction, arrived));
        end else begin
          want = pending_beacons.pop_front();
          if (direction !== want.dir) begin
            report_mismatch($sformatf("direction %0d, expected %0d", direction, want.dir));
          end
          if (arrived !== want.arrived) begin
            report_mismatch($sformatf("arrived %0b, expected %0b", arrived, want.arrived));
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int      thr;
    logic    op;
    sample_t l;
    sample_t r;

    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = dmab_pkg::OP_SLIDE;
    left_sample  = '0;
    right_sample = '0;
    cfg_valid    = 1'b0;
    threshold    = '0;
    req_known    = 1'b0;
    req_want     = '0;
    errors       = 0;
    quiet        = 1'b0;

    // slide on the zeroed window, then wrap the ring
    add_known(dmab_pkg::OP_SLIDE, 10'd1023, 10'd0,    dmab_pkg::DIR_NONE,  1'b0);
    add_known(dmab_pkg::OP_SLIDE, 10'd1023, 10'd1023, dmab_pkg::DIR_NONE,  1'b0);
    add_req  (dmab_pkg::OP_SLIDE, 10'd1023, 10'd1023);
    add_req  (dmab_pkg::OP_SLIDE, 10'd0,    10'd1023);
    add_req  (dmab_pkg::OP_SLIDE, 10'd0,    10'd1023);
    add_req  (dmab_pkg::OP_SLIDE, 10'd1023, 10'd1023);
    add_req  (dmab_pkg::OP_SLIDE, 10'd1,    10'd2);
    // prime: rails, tie to right, one step either side of the threshold
    add_known(dmab_pkg::OP_PRIME, 10'd1023, 10'd1023, dmab_pkg::DIR_RIGHT, 1'b1);
    add_known(dmab_pkg::OP_PRIME, 10'd0,    10'd0,    dmab_pkg::DIR_NONE,  1'b0);
    add_known(dmab_pkg::OP_PRIME, 10'd1023, 10'd0,    dmab_pkg::DIR_LEFT,  1'b1);
    add_known(dmab_pkg::OP_PRIME, 10'd0,    10'd1023, dmab_pkg::DIR_RIGHT, 1'b1);
    add_known(dmab_pkg::OP_PRIME, 10'd513,  10'd512,  dmab_pkg::DIR_LEFT,  1'b1);
    add_known(dmab_pkg::OP_PRIME, 10'd512,  10'd512,  dmab_pkg::DIR_NONE,  1'b0);
    add_known(dmab_pkg::OP_PRIME, 10'd512,  10'd513,  dmab_pkg::DIR_RIGHT, 1'b1);
    add_known(dmab_pkg::OP_PRIME, 10'd1000, 10'd999,  dmab_pkg::DIR_LEFT,  1'b1);
    add_req  (dmab_pkg::OP_SLIDE, 10'd0,    10'd1023);
    // lowest threshold: any nonzero sum counts
    add_cfg  (10'd0);
    add_known(dmab_pkg::OP_PRIME, 10'd0,    10'd0,    dmab_pkg::DIR_NONE,  1'b0);
    add_known(dmab_pkg::OP_PRIME, 10'd1,    10'd0,    dmab_pkg::DIR_LEFT,  1'b1);
    add_req  (dmab_pkg::OP_SLIDE, 10'd0,    10'd1);
    // highest threshold: nothing can exceed it
    add_cfg  (10'd1023);
    add_known(dmab_pkg::OP_PRIME, 10'd1023, 10'd1023, dmab_pkg::DIR_NONE,  1'b0);
    add_req  (dmab_pkg::OP_SLIDE, 10'd1023, 10'd0);
    add_cfg  (sample_t'(dmab_pkg::THRESHOLD_RESET));

    // reset
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_threshold(directed_rows[i].thr);
      end else begin
        send_request(directed_rows[i].op, directed_rows[i].left_val,
                     directed_rows[i].right_val, directed_rows[i].kind == ROW_REQ_KNOWN,
                     directed_rows[i].want);
      end
    end

    // random phases, one threshold each
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       thr = SAMPLE_MAX;
        1:       thr = 0;
        2:       thr = 1;
        default: thr = $urandom_range(50, 970);
      endcase
      write_threshold(sample_t'(thr));
      quiet = (ph == PHASES - 1);
      repeat (PHASE_REQS) begin
        op = ($urandom_range(0, 9) == 0) ? dmab_pkg::OP_PRIME : dmab_pkg::OP_SLIDE;
        l  = pick_sample(thr);
        r  = ($urandom_range(0, 7) == 0) ? l : pick_sample(thr);
        send_request(op, l, r, 1'b0, '0);
      end
    end

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beacons.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
